// File: design/cwf_pkg.sv
// ----------------------------------------------------------------------------
// cwf_pkg
// shared types and constants for the complex wavelet fir unit
// ----------------------------------------------------------------------------
package cwf_pkg;

    localparam int MAX_TAPS_DEF = 512;
    localparam logic [9:0] HALF_LEN_RESET = 10'd208;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] sample;
        logic [8:0]         tap_index;
        logic signed [15:0] tap_real;
        logic signed [15:0] tap_imag;
    } t_in;

    typedef struct packed {
        logic signed [47:0] real_sum;
        logic signed [47:0] imag_sum;
    } t_out;

endpackage

// File: design/cwf_ram.sv
// ----------------------------------------------------------------------------
// cwf_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module cwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/complex_wavelet_fir_unit.sv
// ----------------------------------------------------------------------------
// complex_wavelet_fir_unit
// two-sided complex fir applying a loaded wavelet kernel to a sample stream
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready, payload i_in_data) carries either a
// coefficient pair (one real and one imaginary tap at tap_index) or a sample.
// A coefficient transfer gives no result. A sample transfer shifts the
// delay line and yields one result on the output channel (o_out_valid /
// i_out_ready, payload o_out_data) for the centre sample N-1 samples back,
// N being the clamped half length.
// One folded mac pair walks the taps, one tap pair per cycle. After a sample
// transfer o_in_ready is low through the tap walk, then multiply, accumulate
// and result load; a new sample is not taken until the previous sample's
// result is loaded into the output register.
// The result sits in an output register: if the receiver stalls, the next
// sample is still taken and computed, and the block waits only to load its
// result until the previous one transfers.
// Half length is written through i_cfg_we / i_cfg_wdata, by the user only
// while idle; the block itself does not enforce this. Reset empties the delay
// line (a fill count makes unwritten history read as zero), sets half length
// to 208 and drops any pending result; taps are undefined until written.
// ----------------------------------------------------------------------------
module complex_wavelet_fir_unit #(
    parameter int MAX_TAPS = cwf_pkg::MAX_TAPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cwf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cwf_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [9:0]    i_cfg_wdata
);

    localparam int TW       = $clog2(MAX_TAPS);
    localparam int LINE_LEN = 2 * MAX_TAPS - 1;
    localparam int AW       = $clog2(2 * MAX_TAPS);
    localparam int DEPTH    = 2 ** AW;
    localparam int NW       = ($clog2(MAX_TAPS + 1) > 10) ? $clog2(MAX_TAPS + 1) : 10;
    localparam int IXW      = ($clog2(MAX_TAPS + 1) > 9) ? $clog2(MAX_TAPS + 1) : 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;

    logic [9:0]    r_half_len, n_half_len;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_fill, n_fill;
    logic [TW-1:0] r_ctr, n_ctr;
    logic [TW-1:0] r_k, n_k;

    logic r_p1_valid, n_p1_valid;
    logic r_p1_first, n_p1_first;
    logic r_p1_ev, n_p1_ev;
    logic r_p1_lv, n_p1_lv;
    logic r_p2_valid, n_p2_valid;

    logic signed [32:0] r_prod_re, n_prod_re;
    logic signed [32:0] r_prod_im, n_prod_im;
    logic signed [47:0] r_acc_re, n_acc_re;
    logic signed [47:0] r_acc_im, n_acc_im;

    logic          r_out_valid, n_out_valid;
    cwf_pkg::t_out r_out, n_out;

    logic in_xfer, sample_xfer, coef_xfer, out_xfer;

    logic [IXW-1:0] idx_ext;
    logic           tap_we;
    logic [NW-1:0]  hl_ext, n_clamped;

    logic [AW-1:0] pos_e, pos_l, addr_e, addr_l;
    logic [15:0]   ram_e_rd, ram_l_rd;
    logic [31:0]   tap_rd;

    logic signed [15:0] e_s, l_s, tap_r, tap_i;
    logic signed [16:0] sum_s, diff_s;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign sample_xfer = in_xfer && (i_in_data.opcode == cwf_pkg::OP_SAMPLE);
    assign coef_xfer   = in_xfer && (i_in_data.opcode == cwf_pkg::OP_COEF);
    assign out_xfer    = r_out_valid && i_out_ready;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // out-of-range tap writes are dropped
    assign idx_ext = IXW'(i_in_data.tap_index);
    assign tap_we  = coef_xfer && (idx_ext < IXW'(MAX_TAPS));

    assign hl_ext    = NW'(r_half_len);
    assign n_clamped = (hl_ext == '0) ? NW'(1) :
                       (hl_ext > NW'(MAX_TAPS)) ? NW'(MAX_TAPS) : hl_ext;

    // line positions counted back from the newest sample
    assign pos_e  = AW'(r_ctr) + AW'(r_k);
    assign pos_l  = AW'(r_ctr) - AW'(r_k);
    assign addr_e = r_head - pos_e;
    assign addr_l = r_head - pos_l;

    cwf_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_line_e (
        .i_clk   (i_clk),
        .i_we    (sample_xfer),
        .i_waddr (r_head + AW'(1)),
        .i_wdata (i_in_data.sample),
        .i_raddr (addr_e),
        .o_rdata (ram_e_rd)
    );

    cwf_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_line_l (
        .i_clk   (i_clk),
        .i_we    (sample_xfer),
        .i_waddr (r_head + AW'(1)),
        .i_wdata (i_in_data.sample),
        .i_raddr (addr_l),
        .o_rdata (ram_l_rd)
    );

    cwf_ram #(
        .WIDTH (32),
        .DEPTH (MAX_TAPS)
    ) u_taps (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (idx_ext[TW-1:0]),
        .i_wdata ({i_in_data.tap_real, i_in_data.tap_imag}),
        .i_raddr (r_k),
        .o_rdata (tap_rd)
    );

    // samples beyond the fill count have never been written and read as zero
    assign e_s   = r_p1_ev ? $signed(ram_e_rd) : 16'sd0;
    assign l_s   = r_p1_lv ? $signed(ram_l_rd) : 16'sd0;
    assign tap_r = $signed(tap_rd[31:16]);
    assign tap_i = $signed(tap_rd[15:0]);

    // centre tap uses the centre sample once
    assign sum_s  = r_p1_first ? $signed({e_s[15], e_s}) :
                    $signed({e_s[15], e_s}) + $signed({l_s[15], l_s});
    assign diff_s = r_p1_first ? $signed({e_s[15], e_s}) :
                    $signed({e_s[15], e_s}) - $signed({l_s[15], l_s});

    always_comb begin
        n_state     = r_state;
        n_half_len  = r_half_len;
        n_head      = r_head;
        n_fill      = r_fill;
        n_ctr       = r_ctr;
        n_k         = r_k;
        n_p1_valid  = 1'b0;
        n_p1_first  = (r_k == '0);
        n_p1_ev     = (pos_e < r_fill);
        n_p1_lv     = (pos_l < r_fill);
        n_p2_valid  = r_p1_valid;
        n_prod_re   = tap_r * sum_s;
        n_prod_im   = tap_i * diff_s;
        n_acc_re    = r_acc_re;
        n_acc_im    = r_acc_im;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (i_cfg_we) begin
            n_half_len = i_cfg_wdata;
        end

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        if (r_p2_valid) begin
            n_acc_re = r_acc_re + 48'(r_prod_re);
            n_acc_im = r_acc_im + 48'(r_prod_im);
        end

        case (r_state)
            ST_IDLE: begin
                if (sample_xfer) begin
                    n_head   = r_head + AW'(1);
                    n_fill   = (r_fill == AW'(LINE_LEN)) ? r_fill : r_fill + AW'(1);
                    n_ctr    = TW'(n_clamped - NW'(1));
                    n_k      = '0;
                    n_acc_re = '0;
                    n_acc_im = '0;
                    n_state  = ST_RUN;
                end
            end
            ST_RUN: begin
                n_p1_valid = 1'b1;
                if (r_k == r_ctr) begin
                    n_state = ST_FINISH;
                end else begin
                    n_k = r_k + TW'(1);
                end
            end
            ST_FINISH: begin
                if (!r_p1_valid && !r_p2_valid && !r_out_valid) begin
                    n_out_valid    = 1'b1;
                    n_out.real_sum = r_acc_re;
                    n_out.imag_sum = r_acc_im;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_half_len  <= cwf_pkg::HALF_LEN_RESET;
            r_head      <= '0;
            r_fill      <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_half_len  <= n_half_len;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_p1_valid  <= n_p1_valid;
            r_p2_valid  <= n_p2_valid;
            r_out_valid <= n_out_valid;
        end
        r_ctr      <= n_ctr;
        r_k        <= n_k;
        r_p1_first <= n_p1_first;
        r_p1_ev    <= n_p1_ev;
        r_p1_lv    <= n_p1_lv;
        r_prod_re  <= n_prod_re;
        r_prod_im  <= n_prod_im;
        r_acc_re   <= n_acc_re;
        r_acc_im   <= n_acc_im;
        r_out      <= n_out;
    end

endmodule

// File: design/cwf_checker.sv
// ----------------------------------------------------------------------------
// cwf_checker
// port-level checks on the complex wavelet fir unit, bound to the top level
// ----------------------------------------------------------------------------
module cwf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input cwf_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input cwf_pkg::t_out o_out_data
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed or dropped while stalled");

    // a sample transfer starts a tap walk, so the block goes busy
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_data.opcode == cwf_pkg::OP_SAMPLE))
        |=> !o_in_ready)
        else $error("ready stayed high after a sample transfer");

    // a coefficient transfer completes at once
    a_coef_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_data.opcode == cwf_pkg::OP_COEF))
        |=> o_in_ready)
        else $error("block went busy after a coefficient transfer");

    // a new result only appears at the end of a tap walk
    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind complex_wavelet_fir_unit cwf_checker u_cwf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
